>>> rtl/apa102_strip_frame_builder_top_macros.svh
// Assertion macros for the APA102 frame builder checker.
`ifndef APA102_STRIP_FRAME_BUILDER_TOP_MACROS_SVH
`define APA102_STRIP_FRAME_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APA_SFB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define APA_SFB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/apa_sfb_pkg.sv
// Shared types, constants and helper functions of the APA102 frame builder.
package apa_sfb_pkg;

  localparam int MAX_LEDS = 32;
  localparam int IDX_W    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W    = $clog2(MAX_LEDS + 2);
  localparam int LEN_W    = 6;
  localparam int BRIGHT_W = 5;
  localparam int COLOUR_W = 24;
  localparam int PCT_W    = 7;
  localparam int PROD_W   = 12;
  localparam int QUOT_W   = 23;
  localparam int RECIP_SH = 17;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'd31;
  localparam logic [LEN_W-1:0]    LEN_RESET    = 6'd1;
  localparam logic [PROD_W-1:0]   BRIGHT_MAX   = 12'd31;
  localparam logic [PROD_W-1:0]   PCT_FULL     = 12'd100;
  // ceil(2^17 / 100): exact floor(x / 100) for x up to 3100
  localparam logic [QUOT_W-1:0]   RECIP_100    = 23'd1311;
  localparam logic [7:0]          LED_HDR      = 8'hE0;
  localparam logic [7:0]          END_BYTE     = 8'hFF;
  localparam logic [6:0]          END_ROUND    = 7'd15;
  localparam logic [2:0]          FULL_BYTES   = 3'd4;

  typedef enum logic [1:0] {
    FUNC_ENABLE = 2'd0,
    FUNC_BRIGHT = 2'd1,
    FUNC_COLOUR = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_t;

  typedef enum logic {
    CFG_STRIP_LEN      = 1'b0,
    CFG_DEFAULT_BRIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } state_t;

  typedef enum logic [1:0] {
    WK_START,
    WK_LED,
    WK_END
  } kind_t;

  typedef struct packed {
    logic                colour_we;
    logic                bright_we;
    logic                enable_we;
    logic                bright_reload;
    logic [IDX_W-1:0]    addr;
    logic [COLOUR_W-1:0] colour;
    logic [BRIGHT_W-1:0] bright;
    logic                enable;
  } store_wr_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic [BRIGHT_W-1:0] bright;
    logic                enable;
  } store_rd_t;

  // Effective LED count: zero means one, saturate at the built maximum.
  function automatic logic [LEN_W-1:0] strip_count(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (len == '0) n = LEN_RESET;
    else if (32'(len) > MAX_LEDS) n = LEN_W'(MAX_LEDS);
    return n;
  endfunction

  // pct*31/100, truncating, percent saturated at 100.
  function automatic logic [BRIGHT_W-1:0] pct_to_bright(input logic [PCT_W-1:0] pct);
    logic [PROD_W-1:0] p;
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    p = PROD_W'(pct);
    if (p > PCT_FULL) p = PCT_FULL;
    prod = p * BRIGHT_MAX;
    quot = QUOT_W'(prod) * RECIP_100;
    return quot[RECIP_SH +: BRIGHT_W];
  endfunction

endpackage

>>> rtl/apa_sfb_store.sv
// Per-LED store: colour and brightness memories, enable and valid bits.
module apa_sfb_store import apa_sfb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  store_wr_t           wr,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  input  logic [BRIGHT_W-1:0] default_bright,
  output store_rd_t           rd
);

  logic [COLOUR_W-1:0] colour_mem [MAX_LEDS];
  logic [BRIGHT_W-1:0] bright_mem [MAX_LEDS];

  // Valid bits stand in for the reset / reload value of each entry.
  logic [MAX_LEDS-1:0] colour_valid;
  logic [MAX_LEDS-1:0] bright_valid;
  logic [MAX_LEDS-1:0] enable_bits;

  logic [COLOUR_W-1:0] colour_q;
  logic [BRIGHT_W-1:0] bright_q;
  logic                colour_valid_q;
  logic                bright_valid_q;
  logic                enable_q;

  always_ff @(posedge clk) begin
    if (wr.colour_we) begin
      colour_mem[wr.addr] <= wr.colour;
    end
    if (wr.bright_we) begin
      bright_mem[wr.addr] <= wr.bright;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_valid <= '0;
      bright_valid <= '0;
      enable_bits  <= '0;
    end else begin
      if (wr.colour_we) begin
        colour_valid[wr.addr] <= 1'b1;
      end
      if (wr.enable_we) begin
        enable_bits[wr.addr] <= wr.enable;
      end
      if (wr.bright_reload) begin
        bright_valid <= '0;
      end else if (wr.bright_we) begin
        bright_valid[wr.addr] <= 1'b1;
      end
    end
  end

  // Registered read; holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      colour_q       <= colour_mem[rd_addr];
      bright_q       <= bright_mem[rd_addr];
      colour_valid_q <= colour_valid[rd_addr];
      bright_valid_q <= bright_valid[rd_addr];
      enable_q       <= enable_bits[rd_addr];
    end
  end

  assign rd.colour = colour_valid_q ? colour_q : '0;
  assign rd.bright = bright_valid_q ? bright_q : default_bright;
  assign rd.enable = enable_q;

endmodule

>>> rtl/apa102_strip_frame_builder_top.sv
// Top level of the APA102 strip frame builder.
// Holds per-LED enable, 24-bit colour and 5-bit brightness, and on a flush
// word streams the strip frame as 32-bit words, first byte in bits 31..24:
// a zero start word, one word per LED (0xE0|brightness, blue, green, red, or
// 0xE0,0,0,0 for a disabled LED) and an end word of max(1,(N+15)/16) 0xFF
// bytes flagged by last_word. Set words (enable, brightness percent, colour)
// are accepted back to back while no flush runs; a set word to an index
// at or beyond the LED count is dropped. A flush holds in_stall while the
// sequencer walks the store one entry per cycle, unless the output is
// stalled, through the single registered read port of the colour and
// brightness memories; the output then delivers one word per cycle when
// out_stall is low. The output register decouples the two sides, so a new
// input word can be taken while the tail of a frame is still draining.
// Entries reset by valid bits: no clearing pass after reset, and writing
// default_brightness reloads every brightness entry at once. Configuration
// must be written while idle.
module apa102_strip_frame_builder_top import apa_sfb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [LEN_W-1:0]    cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  input  logic [4:0]          led_index,
  input  logic                turn_on,
  input  logic [PCT_W-1:0]    percent,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         frame_word,
  output logic [2:0]          byte_count,
  output logic                last_word
);

  // configuration registers
  logic [LEN_W-1:0]    strip_length;
  logic [BRIGHT_W-1:0] default_bright;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_length   <= LEN_RESET;
      default_bright <= BRIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_STRIP_LEN:      strip_length   <= cfg_data;
        CFG_DEFAULT_BRIGHT: default_bright <= cfg_data[BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] n_leds;
  assign n_leds = strip_count(strip_length);

  // end frame size
  logic [6:0]  end_sum;
  logic [2:0]  tail_bytes;
  logic [31:0] end_word;
  assign end_sum    = 7'(n_leds) + END_ROUND;
  assign tail_bytes = (end_sum[6:4] == 3'd0) ? 3'd1 : end_sum[6:4];
  always_comb begin
    end_word = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < tail_bytes) end_word[31-8*i -: 8] = END_BYTE;
    end
  end

  // input side
  state_t state, state_next;
  logic   in_acc;
  logic   idx_ok;
  assign in_stall = (state == ST_ISSUE);
  assign in_acc   = in_valid && !in_stall;
  assign idx_ok   = (LEN_W'(led_index) < n_leds);

  store_wr_t wr;
  always_comb begin
    wr               = '0;
    wr.addr          = IDX_W'(led_index);
    wr.colour        = {red, green, blue};
    wr.bright        = pct_to_bright(percent);
    wr.enable        = turn_on;
    wr.bright_reload = cfg_we && (cfg_index_t'(cfg_index) == CFG_DEFAULT_BRIGHT);
    if (in_acc && idx_ok) begin
      unique case (func_t'(func))
        FUNC_ENABLE: wr.enable_we = 1'b1;
        FUNC_BRIGHT: wr.bright_we = 1'b1;
        FUNC_COLOUR: wr.colour_we = 1'b1;
        FUNC_FLUSH:  ;
        default:     ;
      endcase
    end
  end

  // flush sequencer
  logic [CNT_W-1:0] issue_cnt, issue_cnt_next;
  logic             advance;
  logic             issue_go;
  logic             rd_en;
  kind_t            issue_kind;
  logic [CNT_W-1:0] last_cnt;

  assign advance  = !out_valid || !out_stall;
  assign last_cnt = CNT_W'(n_leds) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_cnt <= '0;
    end else begin
      state     <= state_next;
      issue_cnt <= issue_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    issue_cnt_next = issue_cnt;
    issue_go       = 1'b0;
    issue_kind     = WK_LED;
    if (issue_cnt == '0) issue_kind = WK_START;
    else if (issue_cnt == last_cnt) issue_kind = WK_END;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && func_t'(func) == FUNC_FLUSH) begin
          state_next     = ST_ISSUE;
          issue_cnt_next = '0;
        end
      end
      ST_ISSUE: begin
        if (advance) begin
          issue_go       = 1'b1;
          issue_cnt_next = issue_cnt + CNT_W'(1);
          if (issue_cnt == last_cnt) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign rd_en = issue_go && (issue_kind == WK_LED);

  logic [CNT_W-1:0] rd_cnt;
  assign rd_cnt = issue_cnt - CNT_W'(1);

  store_rd_t rd;

  apa_sfb_store u_store (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .rd_en          (rd_en),
    .rd_addr        (rd_cnt[IDX_W-1:0]),
    .default_bright (default_bright),
    .rd             (rd)
  );

  // stage 1: word kind aligned with memory read data
  logic  s1_valid;
  kind_t s1_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= issue_go;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind <= issue_kind;
    end
  end

  // word formatting
  logic [31:0] word_next;
  logic [2:0]  count_next;
  logic        last_next;

  always_comb begin
    word_next  = '0;
    count_next = FULL_BYTES;
    last_next  = 1'b0;
    case (s1_kind)
      WK_START: word_next = '0;
      WK_LED: begin
        if (rd.enable) begin
          word_next = {LED_HDR | 8'(rd.bright), rd.colour[7:0], rd.colour[15:8],
                       rd.colour[23:16]};
        end else begin
          word_next = {LED_HDR, 24'd0};
        end
      end
      WK_END: begin
        word_next  = end_word;
        count_next = tail_bytes;
        last_next  = 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_word <= word_next;
      byte_count <= count_next;
      last_word  <= last_next;
    end
  end

endmodule

>>> rtl/apa_sfb_checker.sv
// Port-level checker for the APA102 frame builder, bound to the top level.
`include "apa102_strip_frame_builder_top_macros.svh"

module apa_sfb_checker import apa_sfb_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] frame_word,
  input logic [2:0]  byte_count,
  input logic        last_word
);

  `APA_SFB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(frame_word) && $stable(last_word), "stalled output word changed")

  `APA_SFB_ASSERT_NOW(a_end_count, clk, rst, out_valid && last_word, byte_count == 3'd1 || byte_count == 3'd2, "end word byte count out of range")

  `APA_SFB_ASSERT_NOW(a_full_count, clk, rst, out_valid && !last_word, byte_count == 3'd4 && (frame_word == 32'd0 || frame_word[31:29] == 3'b111), "bad start or LED word")

  `APA_SFB_ASSERT_NEXT(a_flush_busy, clk, rst, in_valid && !in_stall && func == FUNC_FLUSH, in_stall, "input not held after flush")

endmodule

bind apa102_strip_frame_builder_top apa_sfb_checker u_apa_sfb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .func       (func),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .frame_word (frame_word),
  .byte_count (byte_count),
  .last_word  (last_word)
);
